@@ rtl/core/pfla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types, sizes and codes for the page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int PAGE_BITS = 12;
    localparam int NUM_PAGES = 4096;

    localparam int ADDR_W    = 24;
    localparam int TOP_W     = 25;
    localparam int STATUS_W  = 2;
    localparam int PNUM_W    = ADDR_W - PAGE_BITS;
    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int LINK_W    = $clog2(NUM_PAGES + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = TOP_W;

    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(NUM_PAGES);

    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TOP = 1'b1;

    localparam logic [TOP_W-1:0] MEMORY_TOP_RST = 25'h100_0000;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] page_addr;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_addr;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

@@ rtl/core/pfla_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_ctrl
// Sequencer: takes a request, lets the link read settle, then commits the
// update and loads the result register.
// ----------------------------------------------------------------------------
module pfla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pfla_pkg::t_dp_cmd o_cmd
);

    pfla_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfla_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            pfla_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = pfla_pkg::S_EXEC;
                end
            end
            pfla_pkg::S_EXEC: begin
                // result slot free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = pfla_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfla_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/pfla_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfla_dp
// Datapath: config registers, list head, link memory, free checks and the
// result register.
// ----------------------------------------------------------------------------
module pfla_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfla_pkg::t_dp_cmd                   i_cmd,
    input  pfla_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_we,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfla_pkg::CFG_W-1:0]          i_cfg_data,
    output pfla_pkg::t_out_item                 o_out_item
);

    logic [pfla_pkg::ADDR_W-1:0]   r_kernel_end;
    logic [pfla_pkg::TOP_W-1:0]    r_memory_top;
    logic [pfla_pkg::LINK_W-1:0]   r_head, n_head;
    logic                          r_mode;
    logic [pfla_pkg::ADDR_W-1:0]   r_addr;
    logic [pfla_pkg::LINK_W-1:0]   r_rd_link;
    pfla_pkg::t_out_item           r_out_item, n_out_item;

    logic [pfla_pkg::LINK_W-1:0]   mem_link [pfla_pkg::NUM_PAGES];

    logic [pfla_pkg::PNUM_W-1:0]   page;
    logic [pfla_pkg::IDX_W-1:0]    page_idx;
    logic [pfla_pkg::IDX_W-1:0]    head_idx;
    logic [pfla_pkg::IDX_W-1:0]    cur_idx;
    logic                          bad;
    logic                          free_ok;
    logic                          head_empty;

    assign page       = r_addr[pfla_pkg::ADDR_W-1:pfla_pkg::PAGE_BITS];
    assign page_idx   = pfla_pkg::IDX_W'(page);
    assign head_idx   = pfla_pkg::IDX_W'(r_head);
    assign head_empty = (r_head >= pfla_pkg::EMPTY_MARK);
    assign cur_idx    = head_idx;

    assign bad = (r_addr[pfla_pkg::PAGE_BITS-1:0] != '0)
              || (r_addr < r_kernel_end)
              || ({1'b0, r_addr} >= r_memory_top)
              || (32'(page) >= 32'(pfla_pkg::NUM_PAGES));
    assign free_ok = (r_mode == pfla_pkg::MODE_FREE) && !bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end <= '0;
            r_memory_top <= pfla_pkg::MEMORY_TOP_RST;
            r_head       <= pfla_pkg::EMPTY_MARK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pfla_pkg::CFG_KERNEL_END: begin
                        r_kernel_end <= i_cfg_data[pfla_pkg::ADDR_W-1:0];
                    end
                    pfla_pkg::CFG_MEMORY_TOP: begin
                        r_memory_top <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            r_head <= n_head;
        end
    end

    // link memory: read at head on capture, push on committed free
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_link <= mem_link[head_idx];
        end
        if (i_cmd.commit && free_ok) begin
            mem_link[page_idx] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_in_item.mode;
            r_addr <= i_in_item.page_addr;
        end
        if (i_cmd.commit) begin
            r_out_item <= n_out_item;
        end
    end

    always_comb begin
        n_head                = r_head;
        n_out_item.status     = pfla_pkg::ST_REJECT;
        n_out_item.alloc_addr = '0;
        if (i_cmd.commit) begin
            if (r_mode == pfla_pkg::MODE_FREE) begin
                if (free_ok) begin
                    n_head            = pfla_pkg::LINK_W'(page_idx);
                    n_out_item.status = pfla_pkg::ST_FREED;
                end else begin
                    n_out_item.status = pfla_pkg::ST_REJECT;
                end
            end else if (head_empty) begin
                n_out_item.status = pfla_pkg::ST_EMPTY;
            end else begin
                n_head                = r_rd_link;
                n_out_item.status     = pfla_pkg::ST_ALLOC;
                n_out_item.alloc_addr =
                    pfla_pkg::ADDR_W'(64'(cur_idx) << pfla_pkg::PAGE_BITS);
            end
        end
    end

    assign o_out_item = r_out_item;

endmodule

@@ rtl/core/page_free_list_allocator.sv @@
`timescale 1ns / 1ps
// The result is registered: a request is captured in S_IDLE and its result
// is loaded in S_EXEC once the previous result is taken or draining.
// A new request is accepted only in S_IDLE, after the previous one has
// committed; the head page's link read is registered before head update.
// Reset: synchronous, active low; list empty, kernel end 0, memory top 2^24.
// The link memory is not cleared; only written entries are ever used.
// ----------------------------------------------------------------------------
// page_free_list_allocator
// LIFO physical page allocator with checked frees and a linked free list.
// ----------------------------------------------------------------------------
module page_free_list_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pfla_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pfla_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfla_pkg::CFG_W-1:0]      i_cfg_data
);

    pfla_pkg::t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    pfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pfla_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule
